@@ sv/pdir_pkg.sv @@
// Shared types, constants and helpers for the pulse-distance IR frame decoder.
// No dependencies; every other file of the decoder imports this package.
package pdir_pkg;

   localparam int MEAS_W     = 16;
   localparam int TOL_W      = 7;
   localparam int PROD_W     = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int NOM_COUNT  = 6;
   localparam int WORD_W     = 64;
   localparam int CSUM_W     = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Slots of the nominal-duration table
   localparam int NOM_HDR_MARK   = 0;
   localparam int NOM_HDR_SPACE  = 1;
   localparam int NOM_BIT_MARK   = 2;
   localparam int NOM_ONE_SPACE  = 3;
   localparam int NOM_ZERO_SPACE = 4;
   localparam int NOM_FTR_MARK   = 5;

   localparam logic [TOL_W-1:0]  TOL_MAX   = 7'd100;
   localparam logic [PROD_W-1:0] PCT_SCALE = 24'd100;

   localparam logic [TOL_W-1:0]  TOL_RESET       = 7'd25;
   localparam logic [MEAS_W-1:0] HDR_MARK_RESET  = 16'd4500;
   localparam logic [MEAS_W-1:0] HDR_SPACE_RESET = 16'd4500;
   localparam logic [MEAS_W-1:0] BIT_MARK_RESET  = 16'd560;
   localparam logic [MEAS_W-1:0] ONE_SPACE_RESET = 16'd1690;
   localparam logic [MEAS_W-1:0] ZERO_SPACE_RESET = 16'd560;
   localparam logic [MEAS_W-1:0] FTR_MARK_RESET  = 16'd560;

   typedef enum logic [2:0] {
      REG_TOLERANCE  = 3'd0,
      REG_HDR_MARK   = 3'd1,
      REG_HDR_SPACE  = 3'd2,
      REG_BIT_MARK   = 3'd3,
      REG_ONE_SPACE  = 3'd4,
      REG_ZERO_SPACE = 3'd5,
      REG_FTR_MARK   = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_BITS   = 3'd1,
      PH_FOOTER = 3'd2,
      PH_GOOD   = 3'd3,
      PH_FAIL   = 3'd4
   } phase_type;

   // Scaled window bounds: lo = (100-tol)*N, hi = (100+tol)*N
   typedef struct packed {
      logic [NOM_COUNT-1:0][PROD_W-1:0] lo;
      logic [NOM_COUNT-1:0][PROD_W-1:0] hi;
   } bounds_type;

   // Classification of one request
   typedef struct packed {
      logic hdr_ok;
      logic one_ok;
      logic zero_ok;
      logic ftr_ok;
      logic last;
   } class_type;

   // m lies in [floor(lo/100), floor(hi/100)] exactly when
   // 100*m <= hi and 100*(m+1) > lo
   function automatic logic in_window(input logic [PROD_W-1:0] scaled,
                                      input logic [PROD_W-1:0] scaled_next,
                                      input logic [PROD_W-1:0] lo,
                                      input logic [PROD_W-1:0] hi);
      return (scaled <= hi) && (scaled_next > lo);
   endfunction

   function automatic logic [PROD_W-1:0] times_pct(input logic [MEAS_W-1:0] m);
      logic [PROD_W-1:0] w;
      w = PROD_W'(m);
      return (w << 6) + (w << 5) + (w << 2);
   endfunction

endpackage

@@ sv/pulse_distance_ir_frame_decoder_unit.sv @@
// Top level of the pulse-distance IR frame decoder: register block, front end,
// queue and back end. Depends on pdir_pkg, pdir_csr, pdir_front, pdir_queue, pdir_back.
//
//   channel  dir   handshake              payload
//   req      in    req_valid/req_ready    req_mark_us, req_space_us, req_capture_end
//   rsp      out   rsp_valid/rsp_ready    rsp_frame_valid, rsp_data_word,
//                                         rsp_checksum_byte
//   csr      in    APB, csr_pready = 1    csr_paddr, csr_pwdata, csr_prdata
//
// One request per cycle sustained while rsp does not stall. From acceptance a
// request passes the front stage register (classification against the
// registered window bounds), then the queue into the phase machine, and
// the result then sits in the output register.
// Reset is synchronous and active high; it restores the register defaults and
// empties the pipeline. A stalled rsp channel fills the two-entry queue and then
// the front stage before req_ready drops; requests that end no capture never
// wait on the output register.
module pulse_distance_ir_frame_decoder_unit #(
   parameter int DATA_BITS  = 64,
   parameter int CHECK_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pdir_pkg::MEAS_W-1:0]     req_mark_us,
   input  logic [pdir_pkg::MEAS_W-1:0]     req_space_us,
   input  logic                           req_capture_end,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_frame_valid,
   output logic [pdir_pkg::WORD_W-1:0]     rsp_data_word,
   output logic [pdir_pkg::CSUM_W-1:0]     rsp_checksum_byte,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pdir_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pdir_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pdir_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pdir_pkg::*;

   bounds_type bounds;
   class_type  push_data, pop_data;
   logic       push_valid, push_ready;
   logic       pop_valid, pop_ready;

   // Zero-wait register port
   assign csr_pready = 1'b1;

   // Hold the registers and turn them into scaled window bounds, which are
   // registered once more before they reach classification.
   pdir_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .bounds  (bounds)
   );

   // Register each request and classify it as header, one, zero or footer
   pdir_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mark_us     (req_mark_us),
      .req_space_us    (req_space_us),
      .req_capture_end (req_capture_end),
      .bounds          (bounds),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // Decouple the two halves so each may stall on its own
   pdir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Advance the frame phase, shift in bits, and drop a result on capture end
   pdir_back #(
      .DATA_BITS  (DATA_BITS),
      .CHECK_BITS (CHECK_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_valid   (rsp_frame_valid),
      .rsp_data_word     (rsp_data_word),
      .rsp_checksum_byte (rsp_checksum_byte)
   );

endmodule

@@ sv/pdir_csr.sv @@
// Configuration registers of the IR frame decoder and the registered
// window bounds derived from them. Depends on pdir_pkg.
module pdir_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pdir_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdir_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pdir_pkg::CSR_DATA_W-1:0] prdata,
   output pdir_pkg::bounds_type           bounds
);
   import pdir_pkg::*;

   logic [TOL_W-1:0]                 tol_ff, tol_in;
   logic [NOM_COUNT-1:0][MEAS_W-1:0] nom_ff, nom_in;
   bounds_type                       bounds_ff, bounds_in;
   reg_index_type                    idx;
   logic                             wr_en;
   logic [TOL_W-1:0]                 tol_sat;

   assign idx   = reg_index_type'(paddr[4:2]);
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      tol_in = tol_ff;
      nom_in = nom_ff;
      if (wr_en) begin
         unique case (idx)
            REG_TOLERANCE:  tol_in = pwdata[TOL_W-1:0];
            REG_HDR_MARK:   nom_in[NOM_HDR_MARK]   = pwdata[MEAS_W-1:0];
            REG_HDR_SPACE:  nom_in[NOM_HDR_SPACE]  = pwdata[MEAS_W-1:0];
            REG_BIT_MARK:   nom_in[NOM_BIT_MARK]   = pwdata[MEAS_W-1:0];
            REG_ONE_SPACE:  nom_in[NOM_ONE_SPACE]  = pwdata[MEAS_W-1:0];
            REG_ZERO_SPACE: nom_in[NOM_ZERO_SPACE] = pwdata[MEAS_W-1:0];
            REG_FTR_MARK:   nom_in[NOM_FTR_MARK]   = pwdata[MEAS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_TOLERANCE:  prdata = CSR_DATA_W'(tol_ff);
         REG_HDR_MARK:   prdata = CSR_DATA_W'(nom_ff[NOM_HDR_MARK]);
         REG_HDR_SPACE:  prdata = CSR_DATA_W'(nom_ff[NOM_HDR_SPACE]);
         REG_BIT_MARK:   prdata = CSR_DATA_W'(nom_ff[NOM_BIT_MARK]);
         REG_ONE_SPACE:  prdata = CSR_DATA_W'(nom_ff[NOM_ONE_SPACE]);
         REG_ZERO_SPACE: prdata = CSR_DATA_W'(nom_ff[NOM_ZERO_SPACE]);
         REG_FTR_MARK:   prdata = CSR_DATA_W'(nom_ff[NOM_FTR_MARK]);
         default:        prdata = '0;
      endcase
   end

   // Saturate tolerance at 100 so the lower bound never goes negative
   assign tol_sat = (tol_ff > TOL_MAX) ? TOL_MAX : tol_ff;

   always_comb begin
      for (int i = 0; i < NOM_COUNT; i++) begin
         bounds_in.lo[i] = PROD_W'((PCT_SCALE - PROD_W'(tol_sat)) * PROD_W'(nom_ff[i]));
         bounds_in.hi[i] = PROD_W'((PCT_SCALE + PROD_W'(tol_sat)) * PROD_W'(nom_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff                 <= TOL_RESET;
         nom_ff[NOM_HDR_MARK]   <= HDR_MARK_RESET;
         nom_ff[NOM_HDR_SPACE]  <= HDR_SPACE_RESET;
         nom_ff[NOM_BIT_MARK]   <= BIT_MARK_RESET;
         nom_ff[NOM_ONE_SPACE]  <= ONE_SPACE_RESET;
         nom_ff[NOM_ZERO_SPACE] <= ZERO_SPACE_RESET;
         nom_ff[NOM_FTR_MARK]   <= FTR_MARK_RESET;
      end else begin
         tol_ff <= tol_in;
         nom_ff <= nom_in;
      end
      bounds_ff <= bounds_in;
   end

   assign bounds = bounds_ff;

endmodule

@@ sv/pdir_front.sv @@
// Front end of the IR frame decoder: takes requests into a stage register and
// classifies each against the window bounds. Depends on pdir_pkg.
module pdir_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [pdir_pkg::MEAS_W-1:0] req_mark_us,
   input  logic [pdir_pkg::MEAS_W-1:0] req_space_us,
   input  logic                       req_capture_end,
   input  pdir_pkg::bounds_type       bounds,
   output logic                       push_valid,
   input  logic                       push_ready,
   output pdir_pkg::class_type        push_data
);
   import pdir_pkg::*;

   logic              vld_ff, vld_in;
   logic [MEAS_W-1:0] mark_ff, space_ff;
   logic              last_ff;
   logic              take;
   logic [PROD_W-1:0] mark_sc, mark_sc_next, space_sc, space_sc_next;
   logic              bit_mark_ok;

   assign req_ready = !vld_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      vld_in = vld_ff;
      if (take) begin
         vld_in = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (take) begin
         mark_ff  <= req_mark_us;
         space_ff <= req_space_us;
         last_ff  <= req_capture_end;
      end
   end

   assign mark_sc       = times_pct(mark_ff);
   assign mark_sc_next  = mark_sc + PCT_SCALE;
   assign space_sc      = times_pct(space_ff);
   assign space_sc_next = space_sc + PCT_SCALE;

   assign bit_mark_ok = in_window(mark_sc, mark_sc_next,
                                  bounds.lo[NOM_BIT_MARK], bounds.hi[NOM_BIT_MARK]);

   always_comb begin
      push_data.hdr_ok  = in_window(mark_sc, mark_sc_next,
                                    bounds.lo[NOM_HDR_MARK], bounds.hi[NOM_HDR_MARK])
                       && in_window(space_sc, space_sc_next,
                                    bounds.lo[NOM_HDR_SPACE], bounds.hi[NOM_HDR_SPACE]);
      push_data.one_ok  = bit_mark_ok
                       && in_window(space_sc, space_sc_next,
                                    bounds.lo[NOM_ONE_SPACE], bounds.hi[NOM_ONE_SPACE]);
      push_data.zero_ok = bit_mark_ok
                       && in_window(space_sc, space_sc_next,
                                    bounds.lo[NOM_ZERO_SPACE], bounds.hi[NOM_ZERO_SPACE]);
      push_data.ftr_ok  = in_window(mark_sc, mark_sc_next,
                                    bounds.lo[NOM_FTR_MARK], bounds.hi[NOM_FTR_MARK]);
      push_data.last    = last_ff;
   end

   assign push_valid = vld_ff;

endmodule

@@ sv/pdir_queue.sv @@
// Short queue of classified requests between front and back of the decoder.
// Depends on pdir_pkg.
module pdir_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  pdir_pkg::class_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output pdir_pkg::class_type pop_data
);
   import pdir_pkg::*;

   class_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff, count_in;
   logic                   push, pop;

   assign push_ready = count_ff < QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/pdir_back.sv @@
// Back end of the IR frame decoder: frame phase machine, bit shifters and the
// result register. Depends on pdir_pkg.
module pdir_back #(
   parameter int DATA_BITS  = 64,
   parameter int CHECK_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  pdir_pkg::class_type        pop_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_frame_valid,
   output logic [pdir_pkg::WORD_W-1:0] rsp_data_word,
   output logic [pdir_pkg::CSUM_W-1:0] rsp_checksum_byte
);
   import pdir_pkg::*;

   localparam int TOTAL_BITS = DATA_BITS + CHECK_BITS;
   localparam int CNT_W      = $clog2(TOTAL_BITS + 1);

   phase_type             phase_ff, phase_in, phase_nx;
   logic [CNT_W-1:0]      cnt_ff, cnt_in, cnt_nx;
   logic [DATA_BITS-1:0]  dsh_ff, dsh_in, dsh_nx;
   logic [CHECK_BITS-1:0] csh_ff, csh_in, csh_nx;
   logic                  rv_ff, rv_in;
   logic                  fv_ff, fv_in;
   logic [WORD_W-1:0]     word_ff, word_in;
   logic [CSUM_W-1:0]     csum_ff, csum_in;
   logic [CHECK_BITS+CSUM_W-1:0] csh_wide;
   logic                  pop;
   logic                  good;

   // A request that yields no result never waits on the output register
   assign pop_ready = !pop_data.last || !rv_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      phase_nx = phase_ff;
      cnt_nx   = cnt_ff;
      dsh_nx   = dsh_ff;
      csh_nx   = csh_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pop_data.hdr_ok) begin
               phase_nx = PH_BITS;
               cnt_nx   = '0;
               dsh_nx   = '0;
               csh_nx   = '0;
            end else begin
               phase_nx = PH_FAIL;
            end
         end
         PH_BITS: begin
            if (pop_data.one_ok || pop_data.zero_ok) begin
               if (cnt_ff < CNT_W'(DATA_BITS)) begin
                  dsh_nx = (dsh_ff << 1) | DATA_BITS'(pop_data.one_ok);
               end else begin
                  csh_nx = (csh_ff << 1) | CHECK_BITS'(pop_data.one_ok);
               end
               cnt_nx = cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 >= CNT_W'(TOTAL_BITS)) begin
                  phase_nx = PH_FOOTER;
               end
            end else begin
               phase_nx = PH_FAIL;
            end
         end
         PH_FOOTER: phase_nx = pop_data.ftr_ok ? PH_GOOD : PH_FAIL;
         PH_GOOD:   phase_nx = PH_GOOD;
         PH_FAIL:   phase_nx = PH_FAIL;
         default:   phase_nx = PH_FAIL;
      endcase
   end

   assign good     = phase_nx == PH_GOOD;
   assign csh_wide = {{CSUM_W{1'b0}}, csh_nx};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      dsh_in   = dsh_ff;
      csh_in   = csh_ff;
      rv_in    = rv_ff;
      fv_in    = fv_ff;
      word_in  = word_ff;
      csum_in  = csum_ff;
      if (rsp_ready) begin
         rv_in = 1'b0;
      end
      if (pop) begin
         if (pop_data.last) begin
            rv_in    = 1'b1;
            fv_in    = good;
            word_in  = good ? WORD_W'(dsh_nx) : '0;
            csum_in  = good ? csh_wide[CSUM_W-1:0] : '0;
            phase_in = PH_IDLE;
            cnt_in   = '0;
            dsh_in   = '0;
            csh_in   = '0;
         end else begin
            phase_in = phase_nx;
            cnt_in   = cnt_nx;
            dsh_in   = dsh_nx;
            csh_in   = csh_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         dsh_ff   <= '0;
         csh_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         dsh_ff   <= dsh_in;
         csh_ff   <= csh_in;
         rv_ff    <= rv_in;
      end
      fv_ff   <= fv_in;
      word_ff <= word_in;
      csum_ff <= csum_in;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_frame_valid   = fv_ff;
   assign rsp_data_word     = word_ff;
   assign rsp_checksum_byte = csum_ff;

endmodule
